@@ hdl/lap_pkg.sv @@
// Shared types, sizes and helpers for the 3x3 Laplacian RGB filter.
// No dependencies; lap_cell and the filter top level import this package.
package lap_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);   // column counter / line address
  localparam int ROW_W      = $clog2(MAX_HEIGHT);  // row counter
  localparam int CFG_DATA_W = 13;                  // widest register (image_height)
  localparam int CFG_IDX_W  = 2;
  localparam int PIX_W      = 24;
  localparam int LINE_W     = 2 * PIX_W;           // upper and middle line share one word

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  // Channel order inside a pixel: [2] red, [1] green, [0] blue
  typedef logic [2:0][7:0] pixel_t;
  typedef logic [2:0][9:0] col_sum_t;

  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_last;
  } out_req_t;

  function automatic logic [7:0] lap_clamp(input logic signed [12:0] acc);
    logic [7:0] res;
    if (acc <= 13'sd0) begin
      res = 8'd0;
    end else if (acc >= 13'sd255) begin
      res = 8'd255;
    end else begin
      res = acc[7:0];
    end
    return res;
  endfunction

endpackage

@@ hdl/lap_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module lap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/lap_cell.sv @@
// One window column cell: holds three vertically stacked pixels and hands them on.
// Depends on lap_pkg.
module lap_cell
  import lap_pkg::*;
(
  input  logic     clk,
  input  logic     shift,
  input  column_t  col_in,
  output column_t  col_out,
  output col_sum_t col_sum
);

  column_t col;

  always_ff @(posedge clk) begin
    if (shift) begin
      col <= col_in;
    end
  end

  assign col_out = col;

  // per-channel sum of the three pixels, max 765
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      col_sum[ch] = 10'({2'b00, col.top[ch]}) + 10'({2'b00, col.mid[ch]})
                  + 10'({2'b00, col.bot[ch]});
    end
  end

endmodule

@@ hdl/laplacian_3x3_rgb_filter_top.sv @@
// A result passes through stage A, stage B (the window), stage C and the output register to out_valid.
// One pixel per cycle while the output is not stalled; the line RAM is read and written once per pixel.
// A frame of W x H pixels gives (W-2)*(H-2) results; border pixels give none.
// Reset (rst, synchronous): width 640, height 480, position counters and all valid
// flags cleared. Line RAM contents are not cleared; no clearing pass.
module laplacian_3x3_rgb_filter_top
  import lap_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // pixel requests
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_req_t               in_data,
  // result requests
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_req_t              out_data,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // ---------------------------------------------------------------------------
  // Pipeline control: every stage moves together; only a stalled, full output
  // register holds the chain. A new request is taken whenever the chain moves.
  // ---------------------------------------------------------------------------
  logic adv;
  logic in_acc;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign in_acc   = in_valid && adv;

  // ---------------------------------------------------------------------------
  // Configuration and raster position
  // ---------------------------------------------------------------------------
  logic [11:0]      image_width;
  logic [12:0]      image_height;
  logic [COL_W-1:0] col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic [COL_W-1:0] col_last;   // effective width - 1
  logic [ROW_W-1:0] row_last;   // effective height - 1
  logic             at_col_end;
  logic             at_row_end;

  // sizes limited to 3..MAX
  always_comb begin
    priority if (image_width < 12'd3) begin
      col_last = COL_W'(2);
    end else if (image_width > 12'(MAX_WIDTH)) begin
      col_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      col_last = COL_W'(image_width - 12'd1);
    end
    priority if (image_height < 13'd3) begin
      row_last = ROW_W'(2);
    end else if (image_height > 13'(MAX_HEIGHT)) begin
      row_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      row_last = ROW_W'(image_height - 13'd1);
    end
  end

  assign at_col_end = (col_cnt == col_last);
  assign at_row_end = (row_cnt == row_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 12'd640;
      image_height <= 13'd480;
      col_cnt      <= '0;
      row_cnt      <= '0;
    end else if (cfg_we) begin
      // any write, known index or not, restarts the frame
      if (cfg_index == CFG_IMAGE_WIDTH) begin
        image_width <= cfg_data[11:0];
      end
      if (cfg_index == CFG_IMAGE_HEIGHT) begin
        image_height <= cfg_data;
      end
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (in_acc) begin
      if (at_col_end) begin
        col_cnt <= '0;
        row_cnt <= at_row_end ? '0 : row_cnt + ROW_W'(1);
      end else begin
        col_cnt <= col_cnt + COL_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: pixel registered, line RAM read data arrives for its column
  // ---------------------------------------------------------------------------
  logic             a_valid;
  pixel_t           a_px;
  logic [COL_W-1:0] a_addr;
  logic             a_prod;     // window centre is an interior pixel
  logic             a_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_px   <= {in_data.in_red, in_data.in_green, in_data.in_blue};
      a_addr <= col_cnt;
      a_prod <= (col_cnt >= COL_W'(2)) && (row_cnt >= ROW_W'(2));
      a_last <= at_col_end && at_row_end;
    end
  end

  // Line RAM word: upper line in the high half, middle line in the low half.
  // Written back when stage A moves on, after its read; consecutive pixels never share a column.
  logic [LINE_W-1:0] line_rdata;
  logic              cell_shift;

  assign cell_shift = a_valid && adv;

  lap_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (cell_shift),
    .waddr (a_addr),
    .wdata ({line_rdata[PIX_W-1:0], a_px}),
    .re    (adv),
    .raddr (col_cnt),
    .rdata (line_rdata)
  );

  // ---------------------------------------------------------------------------
  // Window: chain of three column cells, newest on the right
  // ---------------------------------------------------------------------------
  column_t  new_col;
  column_t  col_new, col_ctr, col_old;
  col_sum_t sum_new, sum_ctr, sum_old;

  assign new_col.top = line_rdata[LINE_W-1:PIX_W];
  assign new_col.mid = line_rdata[PIX_W-1:0];
  assign new_col.bot = a_px;

  lap_cell u_cell_new (
    .clk     (clk),
    .shift   (cell_shift),
    .col_in  (new_col),
    .col_out (col_new),
    .col_sum (sum_new)
  );

  lap_cell u_cell_ctr (
    .clk     (clk),
    .shift   (cell_shift),
    .col_in  (col_new),
    .col_out (col_ctr),
    .col_sum (sum_ctr)
  );

  lap_cell u_cell_old (
    .clk     (clk),
    .shift   (cell_shift),
    .col_in  (col_ctr),
    .col_out (col_old),
    .col_sum (sum_old)
  );

  // col_old is only handed on to nobody; its sum is what matters
  logic unused_old;
  assign unused_old = ^col_old;

  // ---------------------------------------------------------------------------
  // Stage B: window holds the item; compute 9*centre - sum of all nine
  // (same as 8*centre - eight neighbours), range -2040..2040
  // ---------------------------------------------------------------------------
  logic                    b_valid;
  logic                    b_last;
  logic [2:0][12:0]        lap_acc;
  logic                    c_valid;
  logic                    c_last;
  logic [2:0][12:0]        c_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid && a_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_shift) begin
      b_last <= a_last;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      lap_acc[ch] = {2'b00, col_ctr.mid[ch], 3'b000} + {5'b00000, col_ctr.mid[ch]}
                  - 13'({3'b000, sum_new[ch]}) - 13'({3'b000, sum_ctr[ch]})
                  - 13'({3'b000, sum_old[ch]});
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: registered kernel sums
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_acc  <= lap_acc;
      c_last <= b_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: clamp to 0..255
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.out_red    <= lap_clamp(c_acc[2]);
      out_data.out_green  <= lap_clamp(c_acc[1]);
      out_data.out_blue   <= lap_clamp(c_acc[0]);
      out_data.frame_last <= c_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // raster position never leaves the configured frame
  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    (col_cnt <= col_last) && (row_cnt <= row_last))
    else $error("raster position outside frame");

  // line RAM write-back never hits the column being read in the same cycle
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (cell_shift && in_acc) |-> (a_addr != col_cnt))
    else $error("line RAM read/write collision");

  // last pixel of a frame wraps both counters
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !cfg_we && at_col_end && at_row_end) |=> (col_cnt == '0) && (row_cnt == '0))
    else $error("frame did not wrap");

  // under a stalled, full output register, stage C holds its item
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && c_valid) |=> c_valid && $stable(c_acc))
    else $error("pipeline moved under stall");

endmodule

@@ tb/sv/tb_laplacian_3x3_rgb_filter_top.sv @@
// Self-checking testbench for laplacian_3x3_rgb_filter_top: streams RGB pixel
// requests, predicts the clamped 3x3 Laplacian of every interior pixel, checks results.
// Depends on lap_pkg (hdl/lap_pkg.sv) and the filter top level.
module tb_laplacian_3x3_rgb_filter_top;
  import lap_pkg::*;

  // Indexes with no register behind them: a write only restarts the frame
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_3 = 2'd3;
  localparam int DUT_LATENCY   = 3;     // pixel accept to result valid
  localparam int RANDOM_PIXELS = 1450;  // back-pressure run plus random frames
  localparam int LONG_HOLD     = 400;   // receiver hold-off, in cycles

  typedef enum {PIX_NOISE, PIX_BINARY, PIX_SMOOTH, PIX_FLAT, PIX_PATTERN} pix_style_t;

  // Tracks the filter state (sizes, line stores, 3x3 window, raster position)
  // and keeps the edge results still owed by the block, oldest first.
  class lap_tracker_t;
    logic [11:0] width_reg;
    logic [12:0] height_reg;
    pixel_t      upper_line [MAX_WIDTH];
    pixel_t      middle_line [MAX_WIDTH];
    pixel_t      win [3][3];   // [column: oldest..newest][row: top..bottom]
    int unsigned col_pos;
    int unsigned row_pos;
    out_req_t    edge_q [$];
    int          n_fail;

    function new();
      width_reg  = 12'd640;
      height_reg = 13'd480;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      col_pos = 0;
      row_pos = 0;
      n_fail  = 0;
    endfunction

    // Any write, known index or not, sends the raster position back to the top.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_IMAGE_WIDTH:  width_reg  = data[11:0];
        CFG_IMAGE_HEIGHT: height_reg = data;
        default: ;
      endcase
      col_pos = 0;
      row_pos = 0;
    endfunction

    function void take_pixel(in_req_t req);
      int unsigned w, h, c, r;
      int          acc, ci, ri, ch;
      pixel_t      px;
      logic [7:0]  lap [3];
      out_req_t    res;
      // sizes outside the legal range are pinned to it
      w = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      h = (height_reg < 3) ? 3 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
      c = (col_pos >= w) ? w - 1 : col_pos;
      r = (row_pos >= h) ? h - 1 : row_pos;
      px = {req.in_red, req.in_green, req.in_blue};
      for (ci = 0; ci < 2; ci++) begin
        for (ri = 0; ri < 3; ri++) win[ci][ri] = win[ci + 1][ri];
      end
      win[2][0] = upper_line[c];
      win[2][1] = middle_line[c];
      win[2][2] = px;
      upper_line[c]  = middle_line[c];
      middle_line[c] = px;
      if (c >= 2 && r >= 2) begin
        for (ch = 0; ch < 3; ch++) begin
          acc = 0;
          for (ci = 0; ci < 3; ci++) begin
            for (ri = 0; ri < 3; ri++) begin
              if (ci == 1 && ri == 1) begin
                acc += 8 * int'(win[ci][ri][ch]);
              end else begin
                acc -= int'(win[ci][ri][ch]);
              end
            end
          end
          lap[ch] = (acc <= 0) ? 8'd0 : (acc >= 255) ? 8'd255 : acc[7:0];
        end
        res.out_red    = lap[2];
        res.out_green  = lap[1];
        res.out_blue   = lap[0];
        res.frame_last = (c == w - 1 && r == h - 1);
        edge_q.push_back(res);
      end
      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
        row_pos = r;
      end
    endfunction

    function void field_check(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        n_fail++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_edge(out_req_t got);
      out_req_t want;
      if (edge_q.size() == 0) begin
        n_fail++;
        $display("%0t: result with none expected, expected none actual %h", $time, got);
      end else begin
        want = edge_q.pop_front();
        field_check("out_red", want.out_red, got.out_red);
        field_check("out_green", want.out_green, got.out_green);
        field_check("out_blue", want.out_blue, got.out_blue);
        field_check("frame_last", want.frame_last, got.frame_last);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  in_req_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_req_t              out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lap_tracker_t sb;
  bit          tx_noisy;     // sender may insert idle bursts
  bit          rx_noisy;     // receiver may insert stall bursts
  bit          calm;         // closing stretch: no idling on either side
  bit          hold_long;    // ask the receiver for one long hold-off
  int unsigned cur_w;        // effective frame size, used to size the stimulus
  int unsigned cur_h;
  int unsigned rand_pixels;

  laplacian_3x3_rgb_filter_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Wait for every owed result, then let the pipeline run on: pixels that give no
  // result may still be in flight when the queue runs dry.
  task automatic drain();
    while (sb.edge_q.size() != 0) @(posedge clk);
    repeat (DUT_LATENCY + 5) @(posedge clk);
  endtask

  // One register write; the block is idle whenever this is called.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val[CFG_DATA_W-1:0]);
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h);
    cfg_write(CFG_IMAGE_WIDTH, w);
    cfg_write(CFG_IMAGE_HEIGHT, h);
    cur_w = (w < 3) ? 3 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
    cur_h = (h < 3) ? 3 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
  endtask

  // Offer n pixel requests back to back (valid stays high between them unless
  // an idle burst is drawn), each one noted in the tracker when accepted.
  task automatic send_pixels(input int unsigned n, input pix_style_t sty);
    in_req_t     px;
    int unsigned gap, i, c, r;
    int          v;
    logic [7:0]  base [3];
    logic [7:0]  slope [3];
    foreach (base[k]) begin
      base[k]  = 8'($urandom);
      slope[k] = 8'($urandom_range(0, 9));
    end
    px = in_req_t'(24'($urandom));
    for (i = 0; i < n; i++) begin
      c = i % cur_w;
      r = i / cur_w;
      case (sty)
        PIX_NOISE: begin
          px = in_req_t'(24'($urandom));
        end
        PIX_BINARY: begin
          // saturates hard both ways
          px.in_red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          px.in_green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          px.in_blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        PIX_SMOOTH: begin
          // ramp along the raster plus a little noise: mostly mid-range results
          v = base[2] + i * slope[2] + $urandom_range(0, 6);
          px.in_red = v[7:0];
          v = base[1] + i * slope[1] + $urandom_range(0, 6);
          px.in_green = v[7:0];
          v = base[0] + i * slope[0] + $urandom_range(0, 6);
          px.in_blue = v[7:0];
        end
        PIX_PATTERN: begin
          // red checkerboard, green bowl, blue single bump at the frame centre
          v = ((c + r) % 2) ? 255 : 0;
          px.in_red = v[7:0];
          v = (c * c + r * r) * 7;
          px.in_green = v[7:0];
          v = (c == 2 && r == 2) ? 20 : 10;
          px.in_blue = v[7:0];
        end
        default: ;  // flat: keep the same color
      endcase
      gap = (tx_noisy && !calm && $urandom_range(0, 9) == 0) ? $urandom_range(1, 17) : 0;
      @(negedge clk);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= px;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      sb.take_pixel(px);
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Result side: stall bursts, plus one long hold-off on request so the block
  // backs up and stalls its pixel input.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
        hold_long = 1'b0;
      end else if (rx_noisy && !calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Every accepted result request is checked against the oldest owed one.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_edge(out_data);
  end

  initial begin
    #10000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned w_raw, h_raw, frames, n, k, lim;
    pix_style_t  sty;
    sb          = new();
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_IMAGE_WIDTH;
    cfg_data    = '0;
    tx_noisy    = 1'b1;
    rx_noisy    = 1'b1;
    calm        = 1'b0;
    hold_long   = 1'b0;
    rand_pixels = 0;
    cur_w       = 640;
    cur_h       = 480;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Hand-built 5x5 frame: both clamps, mid values, frame_last on the last pixel
    set_frame(5, 5);
    send_pixels(25, PIX_PATTERN);
    drain();

    // Sizes below the minimum count as 3: two whole 3x3 frames, one result each
    set_frame(1, 0);
    send_pixels(18, PIX_NOISE);
    drain();

    // Writes to indexes with no register restart a frame left half done
    set_frame(5, 4);
    send_pixels(7, PIX_SMOOTH);
    drain();
    cfg_write(CFG_NO_REG_2, $urandom);
    send_pixels(20, PIX_NOISE);
    drain();
    send_pixels(9, PIX_FLAT);
    drain();
    cfg_write(CFG_NO_REG_3, $urandom);
    send_pixels(20, PIX_BINARY);
    drain();

    // Back-pressure: receiver holds off while the sender keeps offering
    set_frame(8, 8);
    hold_long = 1'b1;
    send_pixels(128, PIX_SMOOTH);
    rand_pixels += 128;
    drain();

    // Random frames; mostly whole frames, some with a broken tail, some
    // restarted mid-way by a write
    while (rand_pixels < RANDOM_PIXELS) begin
      tx_noisy = $urandom_range(0, 3) != 0;
      rx_noisy = $urandom_range(0, 3) != 0;
      calm     = rand_pixels >= RANDOM_PIXELS - 250;
      k = $urandom_range(0, 9);
      if (k < 6) begin
        drain();
        w_raw = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        h_raw = $urandom_range(0, 8);
        set_frame(w_raw, h_raw);
      end else if (k == 6) begin
        drain();
        cfg_write($urandom_range(0, 1) ? CFG_NO_REG_2 : CFG_NO_REG_3, $urandom);
      end
      sty    = pix_style_t'($urandom_range(0, 3));
      frames = $urandom_range(1, 3);
      n      = frames * cur_w * cur_h;
      if ($urandom_range(0, 4) == 0) n += $urandom_range(1, cur_w * cur_h - 1);
      // noisy runs stop where the quiet closing stretch begins; nothing runs past the end
      lim = calm ? RANDOM_PIXELS - rand_pixels : RANDOM_PIXELS - 250 - rand_pixels;
      if (n > lim) n = lim;
      send_pixels(n, sty);
      rand_pixels += n;
    end
    drain();

    if (sb.n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
